### src/urbp_pkg.sv
// ----------------------------------------------------------------------------
// urbp_pkg
// Shared types and constants for the UART transmit/receive ring buffer pair.
// ----------------------------------------------------------------------------
package urbp_pkg;

  localparam int TX_DEPTH_DEF = 16;
  localparam int RX_DEPTH_DEF = 16;
  localparam int BYTE_W       = 8;

  // Request codes carried on in_req_type
  typedef enum logic [1:0] {
    REQ_HOST_WRITE = 2'd0,
    REQ_HOST_READ  = 2'd1,
    REQ_LINE_RX    = 2'd2,
    REQ_TX_READY   = 2'd3
  } req_t;

  // Ring status seen by the control logic before the current item
  typedef struct packed {
    logic empty;     // pointers equal
    logic full;      // advancing the write pointer would meet the read pointer
    logic last_one;  // one pop would empty the ring
  } ring_stat_t;

  // Flags of one item held while its ring read completes
  typedef struct packed {
    logic accepted;
    logic read_valid;
    logic tx_valid;
    logic rx_dropped;
    logic rx_available;
    logic tx_irq_enabled;
    logic data_received;
  } stage_t;

endpackage

### src/urbp_ring.sv
// ----------------------------------------------------------------------------
// urbp_ring
// Circular byte buffer: one synchronous memory, write and read pointers
// that wrap at DEPTH, registered read data.
// ----------------------------------------------------------------------------
module urbp_ring
  import urbp_pkg::*;
#(
  parameter int DEPTH = TX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [BYTE_W-1:0] push_data,
  input  logic              pop,
  output ring_stat_t        stat,
  output logic [BYTE_W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_inc, rd_inc;

  // Wrap by compare so any depth works
  assign wr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  assign stat.empty    = (wr_ptr_r == rd_ptr_r);
  assign stat.full     = (wr_inc == rd_ptr_r);
  assign stat.last_one = (rd_inc == wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = push ? wr_inc : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_inc : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Memory: write at the write pointer, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/uart_ring_buffer_pair.sv
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair
// Transmit and receive byte rings for a UART, driven by one request channel.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one request item: host write, host read, line
//   byte received or transmitter ready (in_req_type), with in_data_byte and
//   in_write_last. Each item yields exactly one result item on the out_
//   channel: write accept, read data, transmit byte, drop flag and status.
//   Each ring holds DEPTH-1 bytes; a write to a full transmit ring is
//   refused (out_accepted low) and the host retries.
//   On acceptance the pointers update, the ring memory read is issued and
//   the item enters the read stage; the registered read data is then
//   captured into the output register when the read stage moves on.
//   Throughput: one item per cycle while out_stall stays low, set by the
//   single read port of each ring memory and the pointer update.
//   When the receiver stalls, the output register holds its item and one
//   more item may be taken into the read stage; in_stall then rises.
//   Reset (rst_n low, synchronous) empties both rings, clears the transmit
//   interrupt enable and the data-received flag, and drops pending items.
// ----------------------------------------------------------------------------
module uart_ring_buffer_pair
  import urbp_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_write_last,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_accepted,
  output logic [BYTE_W-1:0] out_read_data,
  output logic              out_read_valid,
  output logic [BYTE_W-1:0] out_tx_byte,
  output logic              out_tx_valid,
  output logic              out_rx_dropped,
  output logic              out_rx_available,
  output logic              out_tx_irq_enabled,
  output logic              out_data_received
);

  req_t              kind;
  logic              in_acc;
  logic              tx_push, tx_pop, rx_push, rx_pop;
  ring_stat_t        tx_stat, rx_stat;
  logic [BYTE_W-1:0] tx_rd_data, rx_rd_data;

  logic              tx_en_r, tx_en_nxt;
  logic              got_r, got_nxt;

  logic              stage_valid_r, stage_valid_nxt;
  stage_t            stage_r, stage_nxt;
  logic              move;

  logic              out_valid_r, out_valid_nxt;
  stage_t            out_flags_r;
  logic [BYTE_W-1:0] out_read_data_r, out_tx_byte_r;

  assign kind = req_t'(in_req_type);

  // Stage advances into the output register when that register is free
  // or is being emptied this cycle.
  assign move     = stage_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = stage_valid_r && !move;
  assign in_acc   = in_valid && !in_stall;

  // Ring operations for the accepted item
  assign tx_push = in_acc && (kind == REQ_HOST_WRITE) && !tx_stat.full;
  assign tx_pop  = in_acc && (kind == REQ_TX_READY)   && !tx_stat.empty;
  assign rx_push = in_acc && (kind == REQ_LINE_RX)    && !rx_stat.full;
  assign rx_pop  = in_acc && (kind == REQ_HOST_READ)  && !rx_stat.empty;

  urbp_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tx_push),
    .push_data (in_data_byte),
    .pop       (tx_pop),
    .stat      (tx_stat),
    .rd_data   (tx_rd_data)
  );

  urbp_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rx_push),
    .push_data (in_data_byte),
    .pop       (rx_pop),
    .stat      (rx_stat),
    .rd_data   (rx_rd_data)
  );

  // Flags and stage contents for the accepted item
  always_comb begin
    tx_en_nxt = tx_en_r;
    if (tx_push && in_write_last) begin
      tx_en_nxt = 1'b1;
    end else if (in_acc && (kind == REQ_TX_READY) && tx_stat.empty) begin
      // nothing left to send: drop the interrupt enable
      tx_en_nxt = 1'b0;
    end
    got_nxt = got_r | rx_push;

    stage_nxt.accepted       = tx_push;
    stage_nxt.read_valid     = rx_pop;
    stage_nxt.tx_valid       = tx_pop;
    stage_nxt.rx_dropped     = in_acc && (kind == REQ_LINE_RX) && rx_stat.full;
    // a push never empties the ring; a pop empties it only from one entry
    stage_nxt.rx_available   = rx_push || (rx_pop ? !rx_stat.last_one : !rx_stat.empty);
    stage_nxt.tx_irq_enabled = tx_en_nxt;
    stage_nxt.data_received  = got_nxt;

    if (in_acc) begin
      stage_valid_nxt = 1'b1;
    end else if (move) begin
      stage_valid_nxt = 1'b0;
    end else begin
      stage_valid_nxt = stage_valid_r;
    end

    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_en_r       <= 1'b0;
      got_r         <= 1'b0;
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      tx_en_r       <= tx_en_nxt;
      got_r         <= got_nxt;
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload: hold the stage until it moves, zero bytes not tied to the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_r <= stage_nxt;
    end
    if (move) begin
      out_flags_r     <= stage_r;
      out_read_data_r <= stage_r.read_valid ? rx_rd_data : '0;
      out_tx_byte_r   <= stage_r.tx_valid   ? tx_rd_data : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_flags_r.accepted;
  assign out_read_data      = out_read_data_r;
  assign out_read_valid     = out_flags_r.read_valid;
  assign out_tx_byte        = out_tx_byte_r;
  assign out_tx_valid       = out_flags_r.tx_valid;
  assign out_rx_dropped     = out_flags_r.rx_dropped;
  assign out_rx_available   = out_flags_r.rx_available;
  assign out_tx_irq_enabled = out_flags_r.tx_irq_enabled;
  assign out_data_received  = out_flags_r.data_received;

endmodule

### dv/tb_uart_ring_buffer_pair.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_ring_buffer_pair
// Self-checking bench for the UART transmit/receive ring pair. A predictor
// mirrors both rings and the two status flags, builds the expected result of
// every accepted request item and matches it in order against the results
// leaving the block, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_uart_ring_buffer_pair;
  import urbp_pkg::*;

  // One result item as seen on the out_ channel
  typedef struct {
    logic              accepted;
    logic [BYTE_W-1:0] read_data;
    logic              read_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_valid;
    logic              rx_dropped;
    logic              rx_available;
    logic              tx_irq_enabled;
    logic              data_received;
  } ring_result_t;

  // Predictor of both rings plus the queue of results still owed by the block
  class ring_pair_model;
    bit [BYTE_W-1:0] tx_ring [TX_DEPTH_DEF];
    bit [BYTE_W-1:0] rx_ring [RX_DEPTH_DEF];
    int              tx_wr, tx_rd, rx_wr, rx_rd;
    bit              tx_irq_en, got_data;
    ring_result_t    owed_results [$];
    int              mismatches;

    function new();
      tx_wr = 0;
      tx_rd = 0;
      rx_wr = 0;
      rx_rd = 0;
      tx_irq_en = 1'b0;
      got_data = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endfunction

    function int tx_next(int p);
      return (p == TX_DEPTH_DEF - 1) ? 0 : p + 1;
    endfunction

    function int rx_next(int p);
      return (p == RX_DEPTH_DEF - 1) ? 0 : p + 1;
    endfunction

    // Advance the rings by one request item and queue its result
    function void take_request(req_t req, bit [BYTE_W-1:0] data, bit last);
      ring_result_t r;
      r = '{default: '0};
      case (req)
        REQ_HOST_WRITE: begin
          if (tx_next(tx_wr) != tx_rd) begin
            tx_ring[tx_wr] = data;
            tx_wr = tx_next(tx_wr);
            r.accepted = 1'b1;
            if (last) tx_irq_en = 1'b1;
          end
        end
        REQ_HOST_READ: begin
          if (rx_wr != rx_rd) begin
            r.read_data = rx_ring[rx_rd];
            r.read_valid = 1'b1;
            rx_rd = rx_next(rx_rd);
          end
        end
        REQ_LINE_RX: begin
          if (rx_next(rx_wr) != rx_rd) begin
            rx_ring[rx_wr] = data;
            rx_wr = rx_next(rx_wr);
            got_data = 1'b1;
          end else begin
            r.rx_dropped = 1'b1;
          end
        end
        default: begin
          if (tx_wr != tx_rd) begin
            r.tx_byte = tx_ring[tx_rd];
            r.tx_valid = 1'b1;
            tx_rd = tx_next(tx_rd);
          end else begin
            tx_irq_en = 1'b0;
          end
        end
      endcase
      r.rx_available = (rx_wr != rx_rd);
      r.tx_irq_enabled = tx_irq_en;
      r.data_received = got_data;
      owed_results.push_back(r);
    endfunction

    function void check_field(string name, logic [BYTE_W-1:0] got,
                              logic [BYTE_W-1:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endfunction

    // Match one result item against the oldest owed result
    function void match_result(ring_result_t got);
      ring_result_t want;
      if (owed_results.size() == 0) begin
        report("result item with no request item waiting");
        return;
      end
      want = owed_results.pop_front();
      check_field("accepted", BYTE_W'(got.accepted), BYTE_W'(want.accepted));
      check_field("read_data", got.read_data, want.read_data);
      check_field("read_valid", BYTE_W'(got.read_valid), BYTE_W'(want.read_valid));
      check_field("tx_byte", got.tx_byte, want.tx_byte);
      check_field("tx_valid", BYTE_W'(got.tx_valid), BYTE_W'(want.tx_valid));
      check_field("rx_dropped", BYTE_W'(got.rx_dropped), BYTE_W'(want.rx_dropped));
      check_field("rx_available", BYTE_W'(got.rx_available),
                  BYTE_W'(want.rx_available));
      check_field("tx_irq_enabled", BYTE_W'(got.tx_irq_enabled),
                  BYTE_W'(want.tx_irq_enabled));
      check_field("data_received", BYTE_W'(got.data_received),
                  BYTE_W'(want.data_received));
    endfunction
  endclass

  // Clock, reset and block inputs: all known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [1:0]        in_req_type = REQ_HOST_READ;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_write_last = 1'b0;
  logic              out_stall = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic              out_accepted;
  logic [BYTE_W-1:0] out_read_data;
  logic              out_read_valid;
  logic [BYTE_W-1:0] out_tx_byte;
  logic              out_tx_valid;
  logic              out_rx_dropped;
  logic              out_rx_available;
  logic              out_tx_irq_enabled;
  logic              out_data_received;

  // Idle rates in percent, changed per phase
  int                in_idle_pct = 0;
  int                out_idle_pct = 0;

  ring_pair_model    model;
  ring_result_t      observed;

  uart_ring_buffer_pair u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_data_byte      (in_data_byte),
    .in_write_last     (in_write_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_read_data     (out_read_data),
    .out_read_valid    (out_read_valid),
    .out_tx_byte       (out_tx_byte),
    .out_tx_valid      (out_tx_valid),
    .out_rx_dropped    (out_rx_dropped),
    .out_rx_available  (out_rx_available),
    .out_tx_irq_enabled(out_tx_irq_enabled),
    .out_data_received (out_data_received)
  );

  // 2 ns period: high and low for 1 ns each
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: raise stall at random, at the phase's rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  // Monitor both channels on the values present before this edge; match the
  // outgoing result before noting the incoming item, since no item can
  // produce its result in the same cycle it is taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      observed.accepted       = out_accepted;
      observed.read_data      = out_read_data;
      observed.read_valid     = out_read_valid;
      observed.tx_byte        = out_tx_byte;
      observed.tx_valid       = out_tx_valid;
      observed.rx_dropped     = out_rx_dropped;
      observed.rx_available   = out_rx_available;
      observed.tx_irq_enabled = out_tx_irq_enabled;
      observed.data_received  = out_data_received;
      model.match_result(observed);
    end
    if (rst_n && in_valid && !in_stall) begin
      model.take_request(req_t'(in_req_type), in_data_byte, in_write_last);
    end
  end

  // Offer one request item and hold it until the block takes it; idle the
  // sender first at the phase's rate
  task automatic send_item(req_t req, logic [BYTE_W-1:0] data, logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_data_byte  <= data;
    in_write_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
  endtask

  // Random traffic in bursts: each burst leans on one request kind so the
  // rings regularly run full and run dry, with other kinds mixed in as noise
  task automatic run_random(int count);
    int   n;
    int   k;
    int   len;
    req_t lead;
    req_t kind;
    logic last;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 24);
      lead = req_t'($urandom_range(0, 3));
      for (k = 0; k < len; k++) begin
        kind = ($urandom_range(0, 99) < 80) ? lead : req_t'($urandom_range(0, 3));
        // end a write call on the burst's last byte, and now and then sooner
        last = (k == len - 1) || ($urandom_range(0, 3) == 0);
        send_item(kind, BYTE_W'($urandom_range(0, 255)), last);
      end
      n += len;
    end
  endtask

  initial begin
    model = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles rarely, receiver stalls often
    in_idle_pct  = 14;
    out_idle_pct = 78;

    // Directed: both rings empty, flags clear
    send_item(REQ_HOST_READ,  8'h00, 1'b0);  // read from empty receive ring
    send_item(REQ_TX_READY,   8'h00, 1'b0);  // ready tick with nothing to send
    send_item(REQ_HOST_WRITE, 8'h00, 1'b0);  // store without ending the write
    send_item(REQ_HOST_WRITE, 8'hFF, 1'b1);  // last byte: enable goes up
    send_item(REQ_TX_READY,   8'hA5, 1'b1);
    send_item(REQ_TX_READY,   8'h5A, 1'b0);
    send_item(REQ_TX_READY,   8'h00, 1'b0);  // ring now empty: enable drops
    send_item(REQ_LINE_RX,    8'hFF, 1'b0);  // first stored byte sets sticky flag
    send_item(REQ_LINE_RX,    8'h00, 1'b1);
    send_item(REQ_HOST_READ,  8'h00, 1'b0);
    send_item(REQ_HOST_READ,  8'hFF, 1'b1);
    send_item(REQ_HOST_READ,  8'h00, 1'b0);  // empty again, sticky flag stays
    send_item(REQ_HOST_WRITE, 8'h55, 1'b1);
    send_item(REQ_HOST_WRITE, 8'hAA, 1'b0);
    send_item(REQ_TX_READY,   8'h00, 1'b0);
    send_item(REQ_TX_READY,   8'h00, 1'b0);
    send_item(REQ_TX_READY,   8'h00, 1'b1);
    send_item(REQ_LINE_RX,    8'h81, 1'b0);
    send_item(REQ_HOST_READ,  8'h7E, 1'b0);

    run_random(110);
    // Pause the sender until every owed result has come back
    wait_for_results();
    run_random(110);
    wait_for_results();

    // Phase two: sender idles often, receiver stalls rarely
    in_idle_pct  = 78;
    out_idle_pct = 14;
    run_random(215);
    wait_for_results();

    // Phase three: neither side idles
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(215);
    wait_for_results();

    // Let the two-stage pipe settle and catch any stray result
    repeat (8) @(posedge clk);
    if (model.pending() != 0) model.report("results still owed at end of run");

    if (model.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
src/urbp_pkg.sv
src/urbp_ring.sv
src/uart_ring_buffer_pair.sv
dv/tb_uart_ring_buffer_pair.sv
